// File: hdl/clm_pkg.sv
package clm_pkg;

    localparam int IDX_W   = 7;
    localparam int ENTRIES = 1 << IDX_W;
    localparam int DATA_W  = 32;
    localparam int CNT_W   = 7;
    localparam int STEP_W  = IDX_W + 1;

    typedef enum logic [1:0] {
        OP_CREATE = 2'd0,
        OP_INSERT = 2'd1,
        OP_FIND   = 2'd2,
        OP_DELETE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOSPACE  = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_BADPOS   = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CREAD0,
        S_CREAD1,
        S_CWR,
        S_IREAD0,
        S_IREAD1,
        S_IREAD2,
        S_IWR1,
        S_IWR2,
        S_WSTART,
        S_WSTEP,
        S_DWR1,
        S_DWR2,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [IDX_W-1:0]  link_raddr;
        logic              link_we;
        logic [IDX_W-1:0]  link_waddr;
        logic [IDX_W-1:0]  link_wdata;
        logic [IDX_W-1:0]  val_raddr;
        logic              val_we;
        logic [IDX_W-1:0]  val_waddr;
        logic [DATA_W-1:0] val_wdata;
    } mem_req_t;

    typedef struct packed {
        logic [IDX_W-1:0]  link_rdata;
        logic [DATA_W-1:0] val_rdata;
    } mem_rsp_t;

endpackage

// File: hdl/clm_if.sv
interface clm_req_if import clm_pkg::*; ;
    logic                     valid;
    logic                     ready;
    logic [1:0]               op;
    logic [IDX_W-1:0]         list_head;
    logic [IDX_W-1:0]         position;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output op, output list_head, output position,
                    output value, input ready);
    modport sink (input valid, input op, input list_head, input position,
                  input value, output ready);
endinterface

interface clm_rsp_if import clm_pkg::*; ;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] node_index;
    logic [1:0]       status;
    logic [CNT_W-1:0] element_count;

    modport source (output valid, output node_index, output status,
                    output element_count, input ready);
    modport sink (input valid, input node_index, input status,
                  input element_count, output ready);
endinterface

// File: hdl/clm_store.sv
module clm_store import clm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mem_req_t req,
    output mem_rsp_t rsp
);

    logic [IDX_W-1:0]  link_mem [ENTRIES];
    logic [DATA_W-1:0] val_mem  [ENTRIES];

    logic [ENTRIES-1:0] written_reg;
    logic               link_written_reg;
    logic [IDX_W-1:0]   link_addr_reg;
    logic [IDX_W-1:0]   link_q_reg;
    logic [DATA_W-1:0]  val_q_reg;
    logic [IDX_W-1:0]   link_init;

    // entries never written read as the free chain: i -> i+1, last -> null
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg      <= '0;
            link_written_reg <= 1'b0;
        end
        else
        begin
            link_written_reg <= written_reg[req.link_raddr];
            if (req.link_we)
            begin
                written_reg[req.link_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.link_we)
        begin
            link_mem[req.link_waddr] <= req.link_wdata;
        end
        link_q_reg    <= link_mem[req.link_raddr];
        link_addr_reg <= req.link_raddr;
    end

    always_ff @(posedge clk)
    begin
        if (req.val_we)
        begin
            val_mem[req.val_waddr] <= req.val_wdata;
        end
        val_q_reg <= val_mem[req.val_raddr];
    end

    assign link_init = (link_addr_reg == IDX_W'(ENTRIES - 1)) ? '0 : link_addr_reg + 1'b1;

    assign rsp.link_rdata = link_written_reg ? link_q_reg : link_init;
    assign rsp.val_rdata  = val_q_reg;

endmodule

// File: hdl/clm_ctrl.sv
module clm_ctrl import clm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    clm_req_if.sink   req,
    clm_rsp_if.source rsp,
    output mem_req_t  mem_req,
    input  mem_rsp_t  mem_rsp
);

    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [IDX_W-1:0]    posn_reg, posn_next;
    logic [DATA_W-1:0]   val_reg, val_next;
    logic [IDX_W-1:0]    node_reg, node_next;
    logic [IDX_W-1:0]    prev_reg, prev_next;
    logic [IDX_W-1:0]    nxt_reg, nxt_next;
    logic [IDX_W-1:0]    pn_reg, pn_next;
    logic [DATA_W-1:0]   count_reg, count_next;
    logic [STEP_W-1:0]   steps_reg, steps_next;
    logic [IDX_W-1:0]    res_node_reg, res_node_next;
    status_t             res_status_reg, res_status_next;
    logic [CNT_W-1:0]    res_count_reg, res_count_next;
    logic                out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]    out_node_reg, out_node_next;
    status_t             out_status_reg, out_status_next;
    logic [CNT_W-1:0]    out_count_reg, out_count_next;

    op_t               req_op;
    logic              accept;
    logic              bad_head;
    logic              bad_posn;
    logic              link_null;
    logic              val_match;
    logic              walk_end;
    logic              out_free;
    logic [DATA_W-1:0] ins_count;
    logic [DATA_W-1:0] del_count;

    assign req_op    = op_t'(req.op);
    assign accept    = req.valid && req.ready;
    assign bad_head  = (req.list_head == '0);
    assign bad_posn  = (req.position == '0);
    assign link_null = (mem_rsp.link_rdata == '0);
    assign val_match = (mem_rsp.val_rdata == val_reg);
    assign walk_end  = link_null || (steps_reg == STEP_W'(ENTRIES));
    assign out_free  = !out_valid_reg || rsp.ready;
    // a header reused as the new node already holds the inserted value
    assign ins_count = ((head_reg == node_reg) ? val_reg : count_reg) + 1'b1;
    assign del_count = count_reg - 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        head_reg       <= head_next;
        posn_reg       <= posn_next;
        val_reg        <= val_next;
        node_reg       <= node_next;
        prev_reg       <= prev_next;
        nxt_reg        <= nxt_next;
        pn_reg         <= pn_next;
        count_reg      <= count_next;
        steps_reg      <= steps_next;
        res_node_reg   <= res_node_next;
        res_status_reg <= res_status_next;
        res_count_reg  <= res_count_next;
        out_node_reg   <= out_node_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req_op == OP_CREATE)
                        state_next = S_CREAD0;
                    else if (bad_head)
                        state_next = S_EMIT;
                    else if (req_op == OP_INSERT)
                        state_next = bad_posn ? S_EMIT : S_IREAD0;
                    else
                        state_next = S_WSTART;
                end
            end
            S_CREAD0: state_next = link_null ? S_EMIT : S_CREAD1;
            S_CREAD1: state_next = S_CWR;
            S_CWR:    state_next = S_EMIT;
            S_IREAD0: state_next = link_null ? S_EMIT : S_IREAD1;
            S_IREAD1: state_next = S_IREAD2;
            S_IREAD2: state_next = S_IWR1;
            S_IWR1:   state_next = S_IWR2;
            S_IWR2:   state_next = S_EMIT;
            S_WSTART: state_next = link_null ? S_EMIT : S_WSTEP;
            S_WSTEP:
            begin
                if (val_match)
                    state_next = (op_reg == OP_FIND) ? S_EMIT : S_DWR1;
                else if (walk_end)
                    state_next = S_EMIT;
            end
            S_DWR1:   state_next = S_DWR2;
            S_DWR2:   state_next = S_EMIT;
            S_EMIT:   state_next = out_free ? S_IDLE : S_EMIT;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        op_next         = op_reg;
        head_next       = head_reg;
        posn_next       = posn_reg;
        val_next        = val_reg;
        node_next       = node_reg;
        prev_next       = prev_reg;
        nxt_next        = nxt_reg;
        pn_next         = pn_reg;
        count_next      = count_reg;
        steps_next      = steps_reg;
        res_node_next   = res_node_reg;
        res_status_next = res_status_reg;
        res_count_next  = res_count_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_node_next   = out_node_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        mem_req         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next         = req_op;
                    head_next       = req.list_head;
                    posn_next       = req.position;
                    val_next        = req.value;
                    res_node_next   = '0;
                    res_status_next = ST_BADPOS;
                    res_count_next  = '0;
                    mem_req.link_raddr = (req_op == OP_CREATE || req_op == OP_INSERT)
                                         ? '0 : req.list_head;
                    mem_req.val_raddr  = req.list_head;
                end
            end
            S_CREAD0:
            begin
                node_next          = mem_rsp.link_rdata;
                mem_req.link_raddr = mem_rsp.link_rdata;
                res_node_next      = '0;
                res_status_next    = ST_NOSPACE;
                res_count_next     = '0;
            end
            S_CREAD1:
            begin
                mem_req.link_we    = 1'b1;
                mem_req.link_waddr = '0;
                mem_req.link_wdata = mem_rsp.link_rdata;
                mem_req.val_we     = 1'b1;
                mem_req.val_waddr  = node_reg;
                mem_req.val_wdata  = '0;
            end
            S_CWR:
            begin
                mem_req.link_we    = 1'b1;
                mem_req.link_waddr = node_reg;
                mem_req.link_wdata = '0;
                res_node_next      = node_reg;
                res_status_next    = ST_OK;
                res_count_next     = '0;
            end
            S_IREAD0:
            begin
                node_next          = mem_rsp.link_rdata;
                count_next         = mem_rsp.val_rdata;
                mem_req.link_raddr = mem_rsp.link_rdata;
                res_node_next      = '0;
                res_status_next    = ST_NOSPACE;
                res_count_next     = mem_rsp.val_rdata[CNT_W-1:0];
            end
            S_IREAD1:
            begin
                nxt_next           = mem_rsp.link_rdata;
                mem_req.link_raddr = posn_reg;
            end
            S_IREAD2:
            begin
                pn_next            = mem_rsp.link_rdata;
                mem_req.link_we    = 1'b1;
                mem_req.link_waddr = '0;
                mem_req.link_wdata = nxt_reg;
                mem_req.val_we     = 1'b1;
                mem_req.val_waddr  = node_reg;
                mem_req.val_wdata  = val_reg;
            end
            S_IWR1:
            begin
                mem_req.link_we    = 1'b1;
                mem_req.link_waddr = node_reg;
                mem_req.link_wdata = pn_reg;
                mem_req.val_we     = 1'b1;
                mem_req.val_waddr  = head_reg;
                mem_req.val_wdata  = ins_count;
                count_next         = ins_count;
            end
            S_IWR2:
            begin
                mem_req.link_we    = 1'b1;
                mem_req.link_waddr = posn_reg;
                mem_req.link_wdata = node_reg;
                res_node_next      = node_reg;
                res_status_next    = ST_OK;
                res_count_next     = count_reg[CNT_W-1:0];
            end
            S_WSTART:
            begin
                count_next         = mem_rsp.val_rdata;
                node_next          = mem_rsp.link_rdata;
                prev_next          = head_reg;
                steps_next         = STEP_W'(1);
                mem_req.link_raddr = mem_rsp.link_rdata;
                mem_req.val_raddr  = mem_rsp.link_rdata;
                res_node_next      = '0;
                res_status_next    = ST_NOTFOUND;
                res_count_next     = mem_rsp.val_rdata[CNT_W-1:0];
            end
            S_WSTEP:
            begin
                if (val_match)
                begin
                    res_node_next   = node_reg;
                    res_status_next = ST_OK;
                    res_count_next  = count_reg[CNT_W-1:0];
                    // unlink now, fetch the free list head for the next beat
                    if (op_reg == OP_DELETE)
                    begin
                        mem_req.link_we    = 1'b1;
                        mem_req.link_waddr = prev_reg;
                        mem_req.link_wdata = mem_rsp.link_rdata;
                        mem_req.link_raddr = '0;
                    end
                end
                else if (!walk_end)
                begin
                    prev_next          = node_reg;
                    node_next          = mem_rsp.link_rdata;
                    steps_next         = steps_reg + 1'b1;
                    mem_req.link_raddr = mem_rsp.link_rdata;
                    mem_req.val_raddr  = mem_rsp.link_rdata;
                end
            end
            S_DWR1:
            begin
                mem_req.link_we    = 1'b1;
                mem_req.link_waddr = node_reg;
                mem_req.link_wdata = mem_rsp.link_rdata;
            end
            S_DWR2:
            begin
                mem_req.link_we    = 1'b1;
                mem_req.link_waddr = '0;
                mem_req.link_wdata = node_reg;
                mem_req.val_we     = 1'b1;
                mem_req.val_waddr  = head_reg;
                mem_req.val_wdata  = del_count;
                res_count_next     = del_count[CNT_W-1:0];
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_node_next   = res_node_reg;
                    out_status_next = res_status_reg;
                    out_count_next  = res_count_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.node_index    = out_node_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.element_count = out_count_reg;

    a_fail_no_node: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_status_reg == ST_OK) || (out_node_reg == '0))
        else $error("failed operation reports a node");

    a_walk_node: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WSTEP |-> (node_reg != '0) && (prev_reg != '0))
        else $error("list walk on null node");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WSTEP |-> (steps_reg != '0) && (steps_reg <= STEP_W'(ENTRIES)))
        else $error("list walk step count out of range");

    a_no_free_null: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DWR2) |-> mem_req.link_wdata != '0)
        else $error("null node returned to free list");

    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) && !out_free |=> state_reg == S_EMIT)
        else $error("result dropped while output busy");

endmodule

// File: hdl/cursor_linked_list_manager.sv
// throughput: one operation at a time; the list walk reads one node per cycle through
//   the link and value memory read ports, a new beat is taken once the result is registered
// reset: the link store comes up as one free chain through per-entry written bits,
//   no clearing pass; value store contents are undefined until written
module cursor_linked_list_manager import clm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    clm_req_if.sink   req,
    clm_rsp_if.source rsp
);

    mem_req_t mem_req;
    mem_rsp_t mem_rsp;

    clm_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .mem_req (mem_req),
        .mem_rsp (mem_rsp)
    );

    clm_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rsp   (mem_rsp)
    );

endmodule

// File: tb/testbench.sv
module testbench;
    import clm_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int RANDOM_ITEMS   = 1730;
    localparam int PHASE_LEN      = 150;

    typedef struct {
        op_t               op;
        logic [IDX_W-1:0]  head;
        logic [IDX_W-1:0]  posn;
        logic [DATA_W-1:0] value;
    } list_cmd_t;

    typedef struct {
        logic [IDX_W-1:0] node;
        status_t          status;
        logic [CNT_W-1:0] count;
    } list_reply_t;

    logic clk = 1'b0;
    logic rst_n;

    clm_req_if req_ch ();
    clm_rsp_if rsp_ch ();

    cursor_linked_list_manager DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    // shadow copy of the node store
    logic [IDX_W-1:0]  link_mem   [ENTRIES];
    logic [DATA_W-1:0] val_mem    [ENTRIES];
    bit                val_known  [ENTRIES];
    logic [IDX_W-1:0]  link_saved [ENTRIES];
    logic [DATA_W-1:0] val_saved  [ENTRIES];
    bit                known_saved[ENTRIES];

    list_cmd_t   pending_cmds[$];
    list_reply_t planned_replies[$];
    list_reply_t results_due[$];
    int          list_heads[$];
    int          walk_nodes[$];

    int          errors;
    int          checked;
    int          idle_cycles;
    int          op_tally[4];
    int          status_tally[4];
    int          burst_left;
    int          gap_left;
    int          pattern_age;
    logic [15:0] stall_pattern;
    list_cmd_t   drive_cmd;
    list_reply_t exp_reply;
    bit          beat_seen;

    function automatic void reset_store();
        for (int i = 0; i < ENTRIES; i++)
        begin
            link_mem[i]  = (i == ENTRIES - 1) ? '0 : IDX_W'(i + 1);
            val_mem[i]   = '0;
            val_known[i] = 1'b0;
        end
        list_heads.delete();
    endfunction

    // one operation on the shadow store; flags any read of a never-written value
    function automatic void apply_cmd(input list_cmd_t c, output list_reply_t r,
                                      output bit undefined_read);
        logic [IDX_W-1:0] node;
        logic [IDX_W-1:0] prev;
        int               steps;
        bit               hit;
        undefined_read = 1'b0;
        r.node   = '0;
        r.status = ST_OK;
        r.count  = '0;
        hit      = 1'b0;
        if (c.op == OP_CREATE)
        begin
            node = link_mem[0];
            if (node == 0)
                r.status = ST_NOSPACE;
            else
            begin
                link_mem[0]     = link_mem[node];
                val_mem[node]   = '0;
                val_known[node] = 1'b1;
                link_mem[node]  = '0;
                r.node          = node;
            end
            return;
        end
        if (c.head == 0 || (c.op == OP_INSERT && c.posn == 0))
        begin
            r.status = ST_BADPOS;
            return;
        end
        case (c.op)
            OP_INSERT:
            begin
                node = link_mem[0];
                if (node != 0)
                begin
                    link_mem[0]      = link_mem[node];
                    val_mem[node]    = c.value;
                    val_known[node]  = 1'b1;
                    link_mem[node]   = link_mem[c.posn];
                    link_mem[c.posn] = node;
                end
                if (!val_known[c.head])
                    undefined_read = 1'b1;
                if (node == 0)
                    r.status = ST_NOSPACE;
                else
                begin
                    val_mem[c.head] = val_mem[c.head] + 1;
                    r.node          = node;
                end
                r.count = val_mem[c.head][CNT_W-1:0];
            end
            OP_FIND:
            begin
                node = link_mem[c.head];
                for (steps = 0; steps < ENTRIES && node != 0 && !hit; steps++)
                begin
                    if (!val_known[node])
                        undefined_read = 1'b1;
                    if (val_mem[node] == c.value)
                    begin
                        hit    = 1'b1;
                        r.node = node;
                    end
                    else
                        node = link_mem[node];
                end
                if (!hit)
                    r.status = ST_NOTFOUND;
                if (!val_known[c.head])
                    undefined_read = 1'b1;
                r.count = val_mem[c.head][CNT_W-1:0];
            end
            default:
            begin
                prev = c.head;
                for (steps = 0; steps < ENTRIES && !hit; steps++)
                begin
                    node = link_mem[prev];
                    if (node == 0)
                        break;
                    if (!val_known[node])
                        undefined_read = 1'b1;
                    if (val_mem[node] == c.value)
                    begin
                        link_mem[prev] = link_mem[node];
                        link_mem[node] = link_mem[0];
                        link_mem[0]    = node;
                        if (!val_known[c.head])
                            undefined_read = 1'b1;
                        val_mem[c.head] = val_mem[c.head] - 1;
                        r.node          = node;
                        hit             = 1'b1;
                    end
                    else
                        prev = node;
                end
                if (!hit)
                begin
                    r.status = ST_NOTFOUND;
                    if (!val_known[c.head])
                        undefined_read = 1'b1;
                end
                r.count = val_mem[c.head][CNT_W-1:0];
            end
        endcase
    endfunction

    // queue a command unless it would read a value never written; state rolls back then
    function automatic bit plan_cmd(input list_cmd_t c);
        list_reply_t r;
        bit          bad;
        link_saved  = link_mem;
        val_saved   = val_mem;
        known_saved = val_known;
        apply_cmd(c, r, bad);
        if (bad)
        begin
            link_mem  = link_saved;
            val_mem   = val_saved;
            val_known = known_saved;
            return 1'b0;
        end
        if (c.op == OP_CREATE && r.status == ST_OK)
            list_heads.push_back(r.node);
        pending_cmds.push_back(c);
        planned_replies.push_back(r);
        return 1'b1;
    endfunction

    function automatic void queue_cmd(input op_t op, input int head, input int posn,
                                      input logic [DATA_W-1:0] value);
        list_cmd_t c;
        c.op    = op;
        c.head  = IDX_W'(head);
        c.posn  = IDX_W'(posn);
        c.value = value;
        void'(plan_cmd(c));
    endfunction

    function automatic void walk_list(input int head);
        logic [IDX_W-1:0] node;
        walk_nodes.delete();
        node = link_mem[head];
        for (int steps = 0; steps < ENTRIES && node != 0; steps++)
        begin
            walk_nodes.push_back(node);
            node = link_mem[node];
        end
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            return $urandom_range(0, 15);
        if (sel < 50)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'hFFFF_FFFF;
                default: return 32'h0000_0000;
            endcase
        end
        return $urandom;
    endfunction

    // growth phases lean on insert, shrink phases on delete
    function automatic list_cmd_t random_cmd(input bit growth);
        list_cmd_t c;
        int        sel;
        int        h;
        sel     = $urandom_range(0, 99);
        c.op    = OP_CREATE;
        c.head  = IDX_W'($urandom_range(0, ENTRIES - 1));
        c.posn  = IDX_W'($urandom_range(0, ENTRIES - 1));
        c.value = pick_value();
        if (sel < 5)
        begin
            c.op    = op_t'($urandom_range(0, 3));
            c.value = $urandom;
            return c;
        end
        if (list_heads.size() == 0 || sel < (growth ? 12 : 8))
            return c;
        h      = list_heads[$urandom_range(0, list_heads.size() - 1)];
        c.head = IDX_W'(h);
        walk_list(h);
        if (sel < (growth ? 65 : 25))
        begin
            c.op = OP_INSERT;
            sel  = $urandom_range(0, 99);
            if (sel < 3)
                c.posn = '0;
            else if (sel < 7)
                c.posn = IDX_W'($urandom_range(1, ENTRIES - 1));
            else if (sel < 30 || walk_nodes.size() == 0)
                c.posn = IDX_W'(h);
            else
                c.posn = IDX_W'(walk_nodes[$urandom_range(0, walk_nodes.size() - 1)]);
            return c;
        end
        c.op = (sel < (growth ? 82 : 40)) ? OP_FIND : OP_DELETE;
        if (walk_nodes.size() != 0 && $urandom_range(0, 3) != 0)
            c.value = val_mem[walk_nodes[$urandom_range(0, walk_nodes.size() - 1)]];
        return c;
    endfunction

    // request driver: bursts with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid     <= 1'b0;
            req_ch.op        <= '0;
            req_ch.list_head <= '0;
            req_ch.position  <= '0;
            req_ch.value     <= '0;
            burst_left       <= $urandom_range(1, 30);
            gap_left         <= 0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (gap_left != 0)
            begin
                gap_left     <= gap_left - 1;
                req_ch.valid <= 1'b0;
            end
            else if (pending_cmds.size() != 0)
            begin
                drive_cmd         = pending_cmds.pop_front();
                req_ch.valid     <= 1'b1;
                req_ch.op        <= drive_cmd.op;
                req_ch.list_head <= drive_cmd.head;
                req_ch.position  <= drive_cmd.posn;
                req_ch.value     <= drive_cmd.value;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // result receiver: rotating stall pattern, reloaded at random whenever pattern_age wraps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready  <= 1'b0;
            stall_pattern <= 16'hFFFF;
            pattern_age   <= 0;
        end
        else
        begin
            rsp_ch.ready <= stall_pattern[0];
            if (pattern_age == 199)
            begin
                pattern_age <= 0;
                case ($urandom_range(0, 3))
                    0, 1:    stall_pattern <= 16'hFFFF;
                    2:       stall_pattern <= 16'($urandom) | 16'h0001;
                    default: stall_pattern <= 16'h0101;
                endcase
            end
            else
            begin
                pattern_age   <= pattern_age + 1;
                stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
            end
        end
    end

    // monitor: moves predictions on request beats, checks result beats
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            beat_seen = 1'b0;
            if (req_ch.valid && req_ch.ready)
            begin
                beat_seen = 1'b1;
                op_tally[req_ch.op]++;
                if (planned_replies.size() != 0)
                    results_due.push_back(planned_replies.pop_front());
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                beat_seen = 1'b1;
                if (results_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result: expected none, %s %0d %0d %0d",
                             $time, "got node/status/count", rsp_ch.node_index,
                             rsp_ch.status, rsp_ch.element_count);
                end
                else
                begin
                    exp_reply = results_due.pop_front();
                    checked++;
                    status_tally[exp_reply.status]++;
                    if (rsp_ch.node_index !== exp_reply.node ||
                        rsp_ch.status !== exp_reply.status ||
                        rsp_ch.element_count !== exp_reply.count)
                    begin
                        errors++;
                        $display("%0t: mismatch: expected node %0d status %s count %0d,",
                                 $time, exp_reply.node, exp_reply.status.name(),
                                 exp_reply.count);
                        $display("    got node %0d status %0d count %0d",
                                 rsp_ch.node_index, rsp_ch.status, rsp_ch.element_count);
                    end
                end
            end
            idle_cycles <= beat_seen ? 0 : idle_cycles + 1;
        end
    end

    initial
    begin
        int        i;
        int        tries;
        bit        placed;
        bit        growth;
        bit        timed_out;
        list_cmd_t fallback;

        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.op        = '0;
        req_ch.list_head = '0;
        req_ch.position  = '0;
        req_ch.value     = '0;
        rsp_ch.ready     = 1'b0;
        errors           = 0;
        checked          = 0;
        idle_cycles      = 0;
        reset_store();

        // two lists, extreme values, rejects on null header and position zero
        queue_cmd(OP_CREATE, 0, 0, 32'h0);
        queue_cmd(OP_CREATE, 0, 0, 32'h0);
        queue_cmd(OP_INSERT, 1, 1, 32'h7FFF_FFFF);
        queue_cmd(OP_INSERT, 1, 3, 32'h8000_0000);
        queue_cmd(OP_INSERT, 1, 1, 32'h0000_0000);
        queue_cmd(OP_INSERT, 1, 0, 32'h1234);
        queue_cmd(OP_INSERT, 0, 1, 32'h1234);
        queue_cmd(OP_FIND,   0, 0, 32'h0);
        queue_cmd(OP_DELETE, 0, 0, 32'h0);
        queue_cmd(OP_FIND,   1, 0, 32'h8000_0000);
        queue_cmd(OP_FIND,   1, 0, 32'hFFFF_FFFF);
        queue_cmd(OP_FIND,   2, 0, 32'h0);
        queue_cmd(OP_DELETE, 1, 0, 32'h7FFF_FFFF);
        queue_cmd(OP_DELETE, 1, 0, 32'd12345);
        // node counted in list 1 but linked into list 2; deleting it wraps list 2's count
        queue_cmd(OP_INSERT, 1, 2, 32'h66);
        queue_cmd(OP_DELETE, 2, 0, 32'h66);
        // inserting after the node that heads the free list links it to itself
        queue_cmd(OP_INSERT, 1, 3, 32'h77);
        queue_cmd(OP_FIND,   3, 0, 32'h12);
        queue_cmd(OP_DELETE, 3, 0, 32'h12);
        queue_cmd(OP_FIND,   1, 0, 32'h0);
        queue_cmd(OP_INSERT, 2, 2, 32'hFFFF_FFFF);
        queue_cmd(OP_DELETE, 2, 0, 32'hFFFF_FFFF);

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            growth = ((i / PHASE_LEN) % 2) == 0;
            placed = 1'b0;
            for (tries = 0; tries < 40 && !placed; tries++)
                placed = plan_cmd(random_cmd(growth));
            if (!placed)
            begin
                // create reads no stored value, so it always fits
                fallback.op    = OP_CREATE;
                fallback.head  = IDX_W'($urandom_range(0, ENTRIES - 1));
                fallback.posn  = IDX_W'($urandom_range(0, ENTRIES - 1));
                fallback.value = $urandom;
                void'(plan_cmd(fallback));
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        timed_out = 1'b0;
        while (!timed_out && (planned_replies.size() != 0 || results_due.size() != 0))
        begin
            @(negedge clk);
            if (idle_cycles >= WATCHDOG_LIMIT)
                timed_out = 1'b1;
        end

        if (!timed_out)
            repeat (DRAIN_CYCLES) @(negedge clk);
        $display("covered %0d operations: create %0d, insert %0d, find %0d, delete %0d;",
                 op_tally[0] + op_tally[1] + op_tally[2] + op_tally[3],
                 op_tally[OP_CREATE], op_tally[OP_INSERT], op_tally[OP_FIND],
                 op_tally[OP_DELETE]);
        $display("%0d results checked: ok %0d, no space %0d, not found %0d, bad position %0d",
                 checked, status_tally[ST_OK], status_tally[ST_NOSPACE],
                 status_tally[ST_NOTFOUND], status_tally[ST_BADPOS]);
        if (timed_out || errors != 0)
            $display("testbench: done, errors");
        else
            $display("testbench: done, clean");
        $finish;
    end

endmodule

// File: filelist.f
hdl/clm_pkg.sv
hdl/clm_if.sv
hdl/clm_store.sv
hdl/clm_ctrl.sv
hdl/cursor_linked_list_manager.sv
tb/testbench.sv
